@@ hdl/esk_pkg.sv @@
// Shared constants for the elastic scatter kinematics pipeline.
// Used by the square root, CORDIC, divider and top-level modules. No dependencies.
package esk_pkg;

   // integer square root: 52-bit radicand, 26-bit root, one root bit per stage
   localparam int SQ_OUT_W   = 26;
   localparam int SQ_IN_W    = 2 * SQ_OUT_W;
   localparam int SQRT_STEPS = SQ_OUT_W;

   // CORDIC vectoring
   localparam int CORDIC_STEPS = 23;
   localparam int ZQ_W         = 25;
   localparam int CX_W         = 29;
   localparam int ANG_W        = 25;
   localparam int ANGLE_W      = 23;
   localparam logic [ANGLE_W-1:0] ANGLE_90 = 23'd5898240;

   // atan(2^-i) in 2^-16 degree, rounded
   localparam logic [21:0] ATAN_TAB [CORDIC_STEPS] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
      22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833, 22'd917,
      22'd458, 22'd229, 22'd115, 22'd57, 22'd29, 22'd14, 22'd7, 22'd4, 22'd2, 22'd1
   };

   // restoring divider: 60-bit divisor, 32 quotient bits
   localparam int DIV_W     = 60;
   localparam int DIV_STEPS = 32;

   // momentum transfer constants: proton mass 469/500 GeV, 1e6 / 64 = 15625
   localparam logic [31:0] S_HALF       = 32'h8000_0000;
   localparam logic [8:0]  MP_NUM       = 9'd469;
   localparam logic [13:0] Q_SCALE      = 14'd15625;
   localparam logic [13:0] BEAM_E_RESET = 14'd2100;

endpackage

@@ hdl/esk_isqrt.sv @@
// Pipelined integer square root, one root bit resolved per register stage.
// Depends on esk_pkg for widths.
module esk_isqrt (
   input  logic                          clock,
   input  logic                          en,
   input  logic [esk_pkg::SQ_IN_W-1:0]   radicand,
   output logic [esk_pkg::SQ_OUT_W-1:0]  root
);
   import esk_pkg::*;

   logic [SQ_IN_W-1:0]  rem_ff  [SQRT_STEPS];
   logic [SQ_IN_W-1:0]  rem_in  [SQRT_STEPS];
   logic [SQ_OUT_W-1:0] root_ff [SQRT_STEPS];
   logic [SQ_OUT_W-1:0] root_in [SQRT_STEPS];

   // stage k tries root bit (SQRT_STEPS-1-k): rem >= (root << (b+1)) + 4^b
   always_comb begin
      logic [SQ_IN_W+1:0]  rem_w;
      logic [SQ_IN_W+1:0]  trial;
      logic [SQ_OUT_W-1:0] root_w;
      for (int k = 0; k < SQRT_STEPS; k++) begin
         if (k == 0) begin
            rem_w  = (SQ_IN_W+2)'(radicand);
            root_w = '0;
         end else begin
            rem_w  = (SQ_IN_W+2)'(rem_ff[k-1]);
            root_w = root_ff[k-1];
         end
         trial = ((SQ_IN_W+2)'(root_w) << (SQRT_STEPS - k))
               + ((SQ_IN_W+2)'(1) << (2 * (SQRT_STEPS - 1 - k)));
         if (rem_w >= trial) begin
            rem_in[k]  = SQ_IN_W'(rem_w - trial);
            root_in[k] = root_w | (SQ_OUT_W'(1) << (SQRT_STEPS - 1 - k));
         end else begin
            rem_in[k]  = SQ_IN_W'(rem_w);
            root_in[k] = root_w;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < SQRT_STEPS; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
      end
   end

   assign root = root_ff[SQRT_STEPS-1];

endmodule

@@ hdl/esk_cordic.sv @@
// Pipelined CORDIC vectoring: angle of (zq, rq) in 2^-16 degree, clamped to 0..90.
// Depends on esk_pkg for the arctangent table and widths.
module esk_cordic (
   input  logic                           clock,
   input  logic                           en,
   input  logic [esk_pkg::ZQ_W-1:0]       zq,
   input  logic [esk_pkg::SQ_OUT_W-1:0]   rq,
   output logic [esk_pkg::ANGLE_W-1:0]    angle
);
   import esk_pkg::*;

   logic signed [CX_W-1:0]  cx_ff  [CORDIC_STEPS];
   logic signed [CX_W-1:0]  cx_in  [CORDIC_STEPS];
   logic signed [CX_W-1:0]  cy_ff  [CORDIC_STEPS];
   logic signed [CX_W-1:0]  cy_in  [CORDIC_STEPS];
   logic signed [ANG_W-1:0] ang_ff [CORDIC_STEPS];
   logic signed [ANG_W-1:0] ang_in [CORDIC_STEPS];
   logic signed [ANG_W-1:0] ang_last;

   // one micro-rotation per stage, driving cy toward zero
   always_comb begin
      logic signed [CX_W-1:0]  cx_w;
      logic signed [CX_W-1:0]  cy_w;
      logic signed [ANG_W-1:0] ang_w;
      logic signed [ANG_W-1:0] step_w;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (i == 0) begin
            cx_w  = $signed(CX_W'(zq));
            cy_w  = $signed(CX_W'(rq));
            ang_w = '0;
         end else begin
            cx_w  = cx_ff[i-1];
            cy_w  = cy_ff[i-1];
            ang_w = ang_ff[i-1];
         end
         step_w = $signed(ANG_W'(ATAN_TAB[i]));
         if (cy_w > 0) begin
            cx_in[i]  = cx_w + (cy_w >>> i);
            cy_in[i]  = cy_w - (cx_w >>> i);
            ang_in[i] = ang_w + step_w;
         end else begin
            cx_in[i]  = cx_w - (cy_w >>> i);
            cy_in[i]  = cy_w + (cx_w >>> i);
            ang_in[i] = ang_w - step_w;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            cx_ff[i]  <= cx_in[i];
            cy_ff[i]  <= cy_in[i];
            ang_ff[i] <= ang_in[i];
         end
      end
   end

   // clamp to the first quadrant
   assign ang_last = ang_ff[CORDIC_STEPS-1];
   always_comb begin
      if (ang_last < 0) begin
         angle = '0;
      end else if (ang_last > $signed(ANG_W'(ANGLE_90))) begin
         angle = ANGLE_90;
      end else begin
         angle = ANGLE_W'(ang_last);
      end
   end

endmodule

@@ hdl/esk_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Expects rem_init < divisor; the 32 low dividend bits are shifted in MSB first.
// Depends on esk_pkg for widths.
module esk_divider (
   input  logic                            clock,
   input  logic                            en,
   input  logic [esk_pkg::DIV_W-1:0]       rem_init,
   input  logic [esk_pkg::DIV_STEPS-1:0]   low_bits,
   input  logic [esk_pkg::DIV_W-1:0]       divisor,
   output logic [esk_pkg::DIV_STEPS-1:0]   quotient
);
   import esk_pkg::*;

   logic [DIV_W-1:0]     rem_ff [DIV_STEPS];
   logic [DIV_W-1:0]     rem_in [DIV_STEPS];
   logic [DIV_STEPS-1:0] low_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] low_in [DIV_STEPS];
   logic [DIV_W-1:0]     den_ff [DIV_STEPS];
   logic [DIV_W-1:0]     den_in [DIV_STEPS];
   logic [DIV_STEPS-1:0] quo_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] quo_in [DIV_STEPS];

   // shift in one dividend bit, subtract when it fits
   always_comb begin
      logic [DIV_W:0]       part_w;
      logic [DIV_W-1:0]     rem_w;
      logic [DIV_STEPS-1:0] low_w;
      logic [DIV_W-1:0]     den_w;
      logic [DIV_STEPS-1:0] quo_w;
      for (int k = 0; k < DIV_STEPS; k++) begin
         if (k == 0) begin
            rem_w = rem_init;
            low_w = low_bits;
            den_w = divisor;
            quo_w = '0;
         end else begin
            rem_w = rem_ff[k-1];
            low_w = low_ff[k-1];
            den_w = den_ff[k-1];
            quo_w = quo_ff[k-1];
         end
         part_w = {rem_w, low_w[DIV_STEPS-1]};
         den_in[k] = den_w;
         low_in[k] = {low_w[DIV_STEPS-2:0], 1'b0};
         if (part_w >= {1'b0, den_w}) begin
            rem_in[k] = DIV_W'(part_w - {1'b0, den_w});
            quo_in[k] = {quo_w[DIV_STEPS-2:0], 1'b1};
         end else begin
            rem_in[k] = DIV_W'(part_w);
            quo_in[k] = {quo_w[DIV_STEPS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DIV_STEPS; k++) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            den_ff[k] <= den_in[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   assign quotient = quo_ff[DIV_STEPS-1];

endmodule

@@ hdl/elastic_scatter_kinematics_core.sv @@
// Top level of the elastic scatter kinematics pipeline: angle and Q^2 per event.
// Depends on esk_pkg, esk_isqrt, esk_cordic and esk_divider.
//
//   port group  direction  handshake          contents
//   req_*       in         req_valid/ready    cluster count, x, y, z, chamber
//   rsp_*       out        rsp_valid/ready    valid flag, angle, Q^2, chamber
//   csr_*       in         csr_wr_en          beam energy in MeV (14 bits)
//
// One request per cycle while rsp_ready does not stall the pipeline; an accepted
// request passes a 26-stage square root and two 32-stage dividers in series.
// A stall on rsp_ready freezes the whole pipeline; the entry register still takes
// one request while it is empty. Reset clears valid bits and sets beam energy to 2100.
module elastic_scatter_kinematics_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [13:0]         csr_wr_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_cluster_count,
   input  logic signed [14:0]  req_pos_x,
   input  logic signed [14:0]  req_pos_y,
   input  logic [16:0]         req_pos_z,
   input  logic [7:0]          req_chamber_in,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_event_valid,
   output logic [22:0]         rsp_angle_deg,
   output logic [31:0]         rsp_momentum_transfer_sq,
   output logic [7:0]          rsp_chamber_out
);
   import esk_pkg::*;

   typedef struct packed {
      logic       ok;
      logic       zero_z;
      logic [7:0] chamber;
   } side_type;

   // stage numbering after the entry register
   localparam int SQ_OUT_STAGE  = 2 + SQRT_STEPS;
   localparam int LAST_STAGE    = SQ_OUT_STAGE + 2 + DIV_STEPS + 4 + DIV_STEPS;
   localparam int ANG_OUT_STAGE = SQ_OUT_STAGE + CORDIC_STEPS;
   localparam int ANG_DLY       = LAST_STAGE - ANG_OUT_STAGE;

   logic en;

   // beam energy register and derived 469 * E^2
   logic [13:0] beam_e_ff;
   logic [27:0] e2_ff;
   logic [36:0] a_ff;

   // entry register
   logic               in_v_ff;
   logic [7:0]         in_count_ff;
   logic signed [14:0] in_x_ff;
   logic signed [14:0] in_y_ff;
   logic [16:0]        in_z_ff;
   logic [7:0]         in_ch_ff;

   // control and side data pipeline
   logic     valid_ff [1:LAST_STAGE];
   side_type side_ff  [1:LAST_STAGE];

   // squares
   logic signed [29:0] xs;
   logic signed [29:0] ys;
   logic [29:0] p1_ff;
   logic [33:0] zsq1_ff;
   logic [16:0] z1_ff;
   logic [29:0] p2_ff;
   logic [34:0] d2_ff;
   logic [16:0] z2_ff;

   // side data held across the square roots
   logic [29:0] p_dly_ff [SQRT_STEPS];
   logic [16:0] z_dly_ff [SQRT_STEPS];
   logic [SQ_OUT_W-1:0] rq;
   logic [SQ_OUT_W-1:0] dq;
   logic [ZQ_W-1:0]     zq;

   // angle
   logic [ANGLE_W-1:0] cordic_angle;
   logic [ANGLE_W-1:0] angle_dly_ff [ANG_DLY];

   // sin^2 divisor
   logic [SQ_OUT_W-1:0] dq3_ff;
   logic [26:0]         sum3_ff;
   logic [29:0]         p3_ff;
   logic [53:0]         c4_ff;
   logic [29:0]         p4_ff;
   logic [DIV_STEPS-1:0] s_quo;

   // Q^2 terms
   logic [31:0] s5_ff;
   logic [45:0] es6_ff;
   logic [50:0] aslo6_ff;
   logic [49:0] ashi6_ff;
   logic [68:0] as7_ff;
   logic [59:0] cq7_ff;
   logic [45:0] den_sum;
   logic [56:0] ab_hi;
   logic [59:0] rem8_ff;
   logic [31:0] low8_ff;
   logic [59:0] cq8_ff;
   logic        sat8_ff;
   logic        sat_dly_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] q_quo;

   // output register
   logic        rsp_valid_ff;
   logic        rsp_ok_ff;
   logic [22:0] rsp_angle_ff;
   logic [31:0] rsp_q_ff;
   logic [7:0]  rsp_ch_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_v_ff || en;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         beam_e_ff <= BEAM_E_RESET;
      end else if (csr_wr_en) begin
         beam_e_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      e2_ff <= 28'(beam_e_ff) * 28'(beam_e_ff);
      a_ff  <= 37'(e2_ff) * 37'(MP_NUM);
   end

   // entry register and valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 1; k <= LAST_STAGE; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         if (req_valid && req_ready) begin
            in_v_ff <= 1'b1;
         end else if (en) begin
            in_v_ff <= 1'b0;
         end
         if (en) begin
            valid_ff[1] <= in_v_ff;
            for (int k = 2; k <= LAST_STAGE; k++) begin
               valid_ff[k] <= valid_ff[k-1];
            end
            rsp_valid_ff <= valid_ff[LAST_STAGE];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_count_ff <= req_cluster_count;
         in_x_ff     <= req_pos_x;
         in_y_ff     <= req_pos_y;
         in_z_ff     <= req_pos_z;
         in_ch_ff    <= req_chamber_in;
      end
   end

   assign xs = 30'(in_x_ff);
   assign ys = 30'(in_y_ff);

   // side data shift line
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[1].ok      <= (in_count_ff == 8'd1);
         side_ff[1].zero_z  <= (in_z_ff == 17'd0);
         side_ff[1].chamber <= in_ch_ff;
         for (int k = 2; k <= LAST_STAGE; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // stages 1 and 2: r^2 and d^2
   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff   <= $unsigned(xs * xs) + $unsigned(ys * ys);
         zsq1_ff <= 34'(in_z_ff) * 34'(in_z_ff);
         z1_ff   <= in_z_ff;
         p2_ff   <= p1_ff;
         d2_ff   <= 35'(p1_ff) + 35'(zsq1_ff);
         z2_ff   <= z1_ff;
      end
   end

   esk_isqrt u_sqrt_r (
      .clock    (clock),
      .en       (en),
      .radicand (SQ_IN_W'({p2_ff, 16'd0})),
      .root     (rq)
   );

   esk_isqrt u_sqrt_d (
      .clock    (clock),
      .en       (en),
      .radicand (SQ_IN_W'({d2_ff, 16'd0})),
      .root     (dq)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         p_dly_ff[0] <= p2_ff;
         z_dly_ff[0] <= z2_ff;
         for (int k = 1; k < SQRT_STEPS; k++) begin
            p_dly_ff[k] <= p_dly_ff[k-1];
            z_dly_ff[k] <= z_dly_ff[k-1];
         end
      end
   end

   assign zq = {z_dly_ff[SQRT_STEPS-1], 8'd0};

   // polar angle
   esk_cordic u_cordic (
      .clock (clock),
      .en    (en),
      .zq    (zq),
      .rq    (rq),
      .angle (cordic_angle)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         angle_dly_ff[0] <= cordic_angle;
         for (int k = 1; k < ANG_DLY; k++) begin
            angle_dly_ff[k] <= angle_dly_ff[k-1];
         end
      end
   end

   // divisor 2 * dq * (dq + zq)
   always_ff @(posedge clock) begin
      if (en) begin
         dq3_ff  <= dq;
         sum3_ff <= 27'(dq) + 27'(zq);
         p3_ff   <= p_dly_ff[SQRT_STEPS-1];
         c4_ff   <= {53'(dq3_ff) * 53'(sum3_ff), 1'b0};
         p4_ff   <= p3_ff;
      end
   end

   // S = (r^2 << 48) / divisor
   esk_divider u_div_s (
      .clock    (clock),
      .en       (en),
      .rem_init (DIV_W'({p4_ff, 16'd0})),
      .low_bits ('0),
      .divisor  (DIV_W'(c4_ff)),
      .quotient (s_quo)
   );

   assign den_sum = 46'({MP_NUM, 32'd0}) + es6_ff;
   assign ab_hi   = as7_ff[68:12];

   // Q^2 operands
   always_ff @(posedge clock) begin
      if (en) begin
         if (side_ff[SQ_OUT_STAGE + 2 + DIV_STEPS].zero_z || s_quo > S_HALF) begin
            s5_ff <= S_HALF;
         end else begin
            s5_ff <= s_quo;
         end
         es6_ff   <= 46'(beam_e_ff) * 46'(s5_ff);
         aslo6_ff <= 51'(a_ff[18:0]) * 51'(s5_ff);
         ashi6_ff <= 50'(a_ff[36:19]) * 50'(s5_ff);
         as7_ff   <= 69'(aslo6_ff) + (69'(ashi6_ff) << 19);
         cq7_ff   <= 60'(den_sum) * 60'(Q_SCALE);
         sat8_ff  <= (60'(ab_hi) >= cq7_ff);
         rem8_ff  <= (60'(ab_hi) >= cq7_ff) ? '0 : 60'(ab_hi);
         low8_ff  <= {as7_ff[11:0], 20'd0};
         cq8_ff   <= cq7_ff;
      end
   end

   esk_divider u_div_q (
      .clock    (clock),
      .en       (en),
      .rem_init (rem8_ff),
      .low_bits (low8_ff),
      .divisor  (cq8_ff),
      .quotient (q_quo)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         sat_dly_ff[0] <= sat8_ff;
         for (int k = 1; k < DIV_STEPS; k++) begin
            sat_dly_ff[k] <= sat_dly_ff[k-1];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ok_ff <= side_ff[LAST_STAGE].ok;
         rsp_ch_ff <= side_ff[LAST_STAGE].ok ? side_ff[LAST_STAGE].chamber : 8'd0;
         if (!side_ff[LAST_STAGE].ok) begin
            rsp_angle_ff <= '0;
         end else if (side_ff[LAST_STAGE].zero_z) begin
            rsp_angle_ff <= ANGLE_90;
         end else begin
            rsp_angle_ff <= angle_dly_ff[ANG_DLY-1];
         end
         if (!side_ff[LAST_STAGE].ok) begin
            rsp_q_ff <= '0;
         end else if (sat_dly_ff[DIV_STEPS-1]) begin
            rsp_q_ff <= '1;
         end else begin
            rsp_q_ff <= q_quo;
         end
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_event_valid          = rsp_ok_ff;
   assign rsp_angle_deg            = rsp_angle_ff;
   assign rsp_momentum_transfer_sq = rsp_q_ff;
   assign rsp_chamber_out          = rsp_ch_ff;

endmodule
